// ===== rtl/htme_pkg.sv =====
// shared types, constants and microcode encodings for the huffman tree merge engine
// used by every rtl file of the block, no dependencies
`default_nettype none

package htme_pkg;

    localparam int HEAP_DEPTH = 256;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int EXT_W      = IDX_W + 2;
    localparam int WGT_W      = 40;
    localparam int CNT_IN_W   = 32;
    localparam int ID_W       = 9;
    localparam int SYM_W      = 8;
    localparam int UPC_W      = 5;

    localparam logic [ID_W-1:0] FIRST_INTERNAL = 9'd256;

    localparam logic CMD_LEAF  = 1'b0;
    localparam logic CMD_MERGE = 1'b1;

    localparam logic [1:0] ST_LEAF  = 2'd0;
    localparam logic [1:0] ST_MERGE = 2'd1;
    localparam logic [1:0] ST_ROOT  = 2'd2;
    localparam logic [1:0] ST_ERR   = 2'd3;

    typedef struct packed {
        logic [WGT_W-1:0] w;
        logic [ID_W-1:0]  id;
    } entry_t;

    // datapath operations
    localparam logic [4:0] OP_NOP        = 5'd0;
    localparam logic [4:0] OP_LATCH      = 5'd1;
    localparam logic [4:0] OP_LEAF_LOAD  = 5'd2;
    localparam logic [4:0] OP_RD_PARENT  = 5'd3;
    localparam logic [4:0] OP_PU_MOVE    = 5'd4;
    localparam logic [4:0] OP_WR_X       = 5'd5;
    localparam logic [4:0] OP_EMIT_LEAF  = 5'd6;
    localparam logic [4:0] OP_EMIT_ERR   = 5'd7;
    localparam logic [4:0] OP_RD_ROOT    = 5'd8;
    localparam logic [4:0] OP_POP_TAKE   = 5'd9;
    localparam logic [4:0] OP_POP_LAST   = 5'd10;
    localparam logic [4:0] OP_RD_LEFT    = 5'd11;
    localparam logic [4:0] OP_CAP_LEFT   = 5'd12;
    localparam logic [4:0] OP_PICK       = 5'd13;
    localparam logic [4:0] OP_SD_MOVE    = 5'd14;
    localparam logic [4:0] OP_SET_SECOND = 5'd15;
    localparam logic [4:0] OP_MERGE_PUSH = 5'd16;
    localparam logic [4:0] OP_EMIT_MERGE = 5'd17;
    localparam logic [4:0] OP_EMIT_ROOT  = 5'd18;

    // jump conditions
    localparam logic [3:0] C_NEXT             = 4'd0;
    localparam logic [3:0] C_ALWAYS           = 4'd1;
    localparam logic [3:0] C_NSTART           = 4'd2;
    localparam logic [3:0] C_IS_MERGE         = 4'd3;
    localparam logic [3:0] C_FULL             = 4'd4;
    localparam logic [3:0] C_CNT_ZERO         = 4'd5;
    localparam logic [3:0] C_CNT_ONE          = 4'd6;
    localparam logic [3:0] C_POS_ZERO         = 4'd7;
    localparam logic [3:0] C_PAR_NOT_HEAVIER  = 4'd8;
    localparam logic [3:0] C_L_OOB            = 4'd9;
    localparam logic [3:0] C_SECOND           = 4'd10;
    localparam logic [3:0] C_PICK_NOT_LIGHTER = 4'd11;

    // program steps
    localparam logic [UPC_W-1:0] S_IDLE        = 5'd0;
    localparam logic [UPC_W-1:0] S_DISPATCH    = 5'd1;
    localparam logic [UPC_W-1:0] S_LEAF_CHK    = 5'd2;
    localparam logic [UPC_W-1:0] S_LEAF_LOAD   = 5'd3;
    localparam logic [UPC_W-1:0] S_PU_LOOP     = 5'd4;
    localparam logic [UPC_W-1:0] S_PU_READ     = 5'd5;
    localparam logic [UPC_W-1:0] S_PU_TEST     = 5'd6;
    localparam logic [UPC_W-1:0] S_PU_BACK     = 5'd7;
    localparam logic [UPC_W-1:0] S_PU_PLACE    = 5'd8;
    localparam logic [UPC_W-1:0] S_EMIT_LEAF   = 5'd9;
    localparam logic [UPC_W-1:0] S_ERR         = 5'd10;
    localparam logic [UPC_W-1:0] S_MERGE_CHK   = 5'd11;
    localparam logic [UPC_W-1:0] S_ROOT_READ   = 5'd12;
    localparam logic [UPC_W-1:0] S_POP_TAKE    = 5'd13;
    localparam logic [UPC_W-1:0] S_POP_LAST    = 5'd14;
    localparam logic [UPC_W-1:0] S_SD_LOOP     = 5'd15;
    localparam logic [UPC_W-1:0] S_SD_LEFT     = 5'd16;
    localparam logic [UPC_W-1:0] S_SD_PICK     = 5'd17;
    localparam logic [UPC_W-1:0] S_SD_TEST     = 5'd18;
    localparam logic [UPC_W-1:0] S_SD_BACK     = 5'd19;
    localparam logic [UPC_W-1:0] S_SD_PLACE    = 5'd20;
    localparam logic [UPC_W-1:0] S_POP_DONE    = 5'd21;
    localparam logic [UPC_W-1:0] S_POP_AGAIN   = 5'd22;
    localparam logic [UPC_W-1:0] S_MERGE_PUSH  = 5'd23;
    localparam logic [UPC_W-1:0] S_EMIT_MERGE  = 5'd24;
    localparam logic [UPC_W-1:0] S_EMIT_ROOT   = 5'd25;

    typedef struct packed {
        logic [4:0]       op;
        logic [3:0]       cond;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic is_merge;
        logic full;
        logic cnt_zero;
        logic cnt_one;
        logic pos_zero;
        logic par_not_heavier;
        logic l_oob;
        logic second;
        logic pick_not_lighter;
    } flags_t;

endpackage

`default_nettype wire

// ===== rtl/htme_heap_ram.sv =====
// heap storage: one write port, one read port with registered read data
// depends on htme_pkg for depth and entry type
`default_nettype none

module htme_heap_ram (
    input  wire logic                       clk,
    input  wire logic                       wen,
    input  wire logic [htme_pkg::IDX_W-1:0] waddr,
    input  wire htme_pkg::entry_t           wdata,
    input  wire logic [htme_pkg::IDX_W-1:0] raddr,
    output htme_pkg::entry_t                rdata
);

    htme_pkg::entry_t mem [htme_pkg::HEAP_DEPTH];
    htme_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/htme_ucode_rom.sv =====
// microcode program: one control word per step of the sequencer
// depends on htme_pkg for step, operation and condition codes
`default_nettype none

module htme_ucode_rom (
    input  wire logic [htme_pkg::UPC_W-1:0] upc,
    output htme_pkg::ctrl_t                 ctrl
);

    always_comb
    begin
        unique case (upc)
            htme_pkg::S_IDLE:       ctrl = '{htme_pkg::OP_LATCH,      htme_pkg::C_NSTART,
                                             htme_pkg::S_IDLE};
            htme_pkg::S_DISPATCH:   ctrl = '{htme_pkg::OP_NOP,        htme_pkg::C_IS_MERGE,
                                             htme_pkg::S_MERGE_CHK};
            htme_pkg::S_LEAF_CHK:   ctrl = '{htme_pkg::OP_NOP,        htme_pkg::C_FULL,
                                             htme_pkg::S_ERR};
            htme_pkg::S_LEAF_LOAD:  ctrl = '{htme_pkg::OP_LEAF_LOAD,  htme_pkg::C_NEXT,
                                             htme_pkg::S_IDLE};
            htme_pkg::S_PU_LOOP:    ctrl = '{htme_pkg::OP_NOP,        htme_pkg::C_POS_ZERO,
                                             htme_pkg::S_PU_PLACE};
            htme_pkg::S_PU_READ:    ctrl = '{htme_pkg::OP_RD_PARENT,  htme_pkg::C_NEXT,
                                             htme_pkg::S_IDLE};
            htme_pkg::S_PU_TEST:    ctrl = '{htme_pkg::OP_PU_MOVE,    htme_pkg::C_PAR_NOT_HEAVIER,
                                             htme_pkg::S_PU_PLACE};
            htme_pkg::S_PU_BACK:    ctrl = '{htme_pkg::OP_NOP,        htme_pkg::C_ALWAYS,
                                             htme_pkg::S_PU_LOOP};
            htme_pkg::S_PU_PLACE:   ctrl = '{htme_pkg::OP_WR_X,       htme_pkg::C_IS_MERGE,
                                             htme_pkg::S_EMIT_MERGE};
            htme_pkg::S_EMIT_LEAF:  ctrl = '{htme_pkg::OP_EMIT_LEAF,  htme_pkg::C_ALWAYS,
                                             htme_pkg::S_IDLE};
            htme_pkg::S_ERR:        ctrl = '{htme_pkg::OP_EMIT_ERR,   htme_pkg::C_ALWAYS,
                                             htme_pkg::S_IDLE};
            htme_pkg::S_MERGE_CHK:  ctrl = '{htme_pkg::OP_NOP,        htme_pkg::C_CNT_ZERO,
                                             htme_pkg::S_ERR};
            htme_pkg::S_ROOT_READ:  ctrl = '{htme_pkg::OP_RD_ROOT,    htme_pkg::C_CNT_ONE,
                                             htme_pkg::S_EMIT_ROOT};
            htme_pkg::S_POP_TAKE:   ctrl = '{htme_pkg::OP_POP_TAKE,   htme_pkg::C_CNT_ONE,
                                             htme_pkg::S_POP_DONE};
            htme_pkg::S_POP_LAST:   ctrl = '{htme_pkg::OP_POP_LAST,   htme_pkg::C_NEXT,
                                             htme_pkg::S_IDLE};
            htme_pkg::S_SD_LOOP:    ctrl = '{htme_pkg::OP_RD_LEFT,    htme_pkg::C_L_OOB,
                                             htme_pkg::S_SD_PLACE};
            htme_pkg::S_SD_LEFT:    ctrl = '{htme_pkg::OP_CAP_LEFT,   htme_pkg::C_NEXT,
                                             htme_pkg::S_IDLE};
            htme_pkg::S_SD_PICK:    ctrl = '{htme_pkg::OP_PICK,       htme_pkg::C_NEXT,
                                             htme_pkg::S_IDLE};
            htme_pkg::S_SD_TEST:    ctrl = '{htme_pkg::OP_SD_MOVE,    htme_pkg::C_PICK_NOT_LIGHTER,
                                             htme_pkg::S_SD_PLACE};
            htme_pkg::S_SD_BACK:    ctrl = '{htme_pkg::OP_NOP,        htme_pkg::C_ALWAYS,
                                             htme_pkg::S_SD_LOOP};
            htme_pkg::S_SD_PLACE:   ctrl = '{htme_pkg::OP_WR_X,       htme_pkg::C_NEXT,
                                             htme_pkg::S_IDLE};
            htme_pkg::S_POP_DONE:   ctrl = '{htme_pkg::OP_SET_SECOND, htme_pkg::C_SECOND,
                                             htme_pkg::S_MERGE_PUSH};
            htme_pkg::S_POP_AGAIN:  ctrl = '{htme_pkg::OP_RD_ROOT,    htme_pkg::C_ALWAYS,
                                             htme_pkg::S_POP_TAKE};
            htme_pkg::S_MERGE_PUSH: ctrl = '{htme_pkg::OP_MERGE_PUSH, htme_pkg::C_ALWAYS,
                                             htme_pkg::S_PU_LOOP};
            htme_pkg::S_EMIT_MERGE: ctrl = '{htme_pkg::OP_EMIT_MERGE, htme_pkg::C_ALWAYS,
                                             htme_pkg::S_IDLE};
            htme_pkg::S_EMIT_ROOT:  ctrl = '{htme_pkg::OP_EMIT_ROOT,  htme_pkg::C_ALWAYS,
                                             htme_pkg::S_IDLE};
            default:                ctrl = '{htme_pkg::OP_NOP,        htme_pkg::C_ALWAYS,
                                             htme_pkg::S_IDLE};
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/htme_datapath.sv =====
// heap datapath: command latch, heap count, moving entry, popped entries and result registers
// depends on htme_pkg; drives the heap ram ports and reports branch flags to the sequencer
`default_nettype none

module htme_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [4:0]                    op,
    input  wire logic                          cmd,
    input  wire logic [htme_pkg::SYM_W-1:0]    symbol,
    input  wire logic [htme_pkg::CNT_IN_W-1:0] leaf_count,
    output logic                               ram_wen,
    output logic [htme_pkg::IDX_W-1:0]         ram_waddr,
    output htme_pkg::entry_t                   ram_wdata,
    output logic [htme_pkg::IDX_W-1:0]         ram_raddr,
    input  wire htme_pkg::entry_t              ram_rdata,
    output htme_pkg::flags_t                   flags,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [htme_pkg::ID_W-1:0]          left_node,
    output logic [htme_pkg::ID_W-1:0]          right_node,
    output logic [htme_pkg::ID_W-1:0]          new_node,
    output logic [htme_pkg::WGT_W-1:0]         weight
);

    localparam int IW = htme_pkg::IDX_W;
    localparam int CW = htme_pkg::CNT_W;
    localparam int EW = htme_pkg::EXT_W;
    localparam int WW = htme_pkg::WGT_W;
    localparam int DW = htme_pkg::ID_W;

    logic                          cmd_reg;
    logic [htme_pkg::SYM_W-1:0]    sym_reg;
    logic [htme_pkg::CNT_IN_W-1:0] cnt_reg;

    logic [CW-1:0] count_reg;
    logic [DW-1:0] next_id_reg;
    logic          second_reg;
    logic          done_reg;

    logic [IW-1:0]    pos_reg;
    logic [IW-1:0]    pick_reg;
    htme_pkg::entry_t x_reg;
    htme_pkg::entry_t a_reg;
    htme_pkg::entry_t b_reg;
    htme_pkg::entry_t lw_reg;
    htme_pkg::entry_t child_reg;

    logic [1:0]    status_reg;
    logic [DW-1:0] left_reg;
    logic [DW-1:0] right_reg;
    logic [DW-1:0] node_reg;
    logic [WW-1:0] weight_reg;

    logic [IW-1:0] parent_idx;
    logic [EW-1:0] l_ext;
    logic [EW-1:0] r_ext;
    logic [EW-1:0] count_ext;
    logic [CW-1:0] count_m1;
    logic          r_in;
    logic          par_heavier;
    logic          pick_lighter;
    logic [WW:0]   sum_full;
    logic [WW-1:0] sum_sat;
    logic          emit_op;

    assign parent_idx   = IW'((pos_reg - IW'(1)) >> 1);
    assign l_ext        = {1'b0, pos_reg, 1'b1};
    assign r_ext        = l_ext + EW'(1);
    assign count_ext    = EW'(count_reg);
    assign count_m1     = count_reg - CW'(1);
    assign r_in         = r_ext < count_ext;
    assign par_heavier  = ram_rdata.w > x_reg.w;
    assign pick_lighter = child_reg.w < x_reg.w;
    assign sum_full     = {1'b0, a_reg.w} + {1'b0, b_reg.w};
    // saturate the merged weight
    assign sum_sat      = sum_full[WW] ? {WW{1'b1}} : sum_full[WW-1:0];
    assign emit_op      = (op == htme_pkg::OP_EMIT_LEAF) || (op == htme_pkg::OP_EMIT_ERR)
                       || (op == htme_pkg::OP_EMIT_MERGE) || (op == htme_pkg::OP_EMIT_ROOT);

    always_comb
    begin
        flags.is_merge         = cmd_reg == htme_pkg::CMD_MERGE;
        flags.full             = count_reg == CW'(htme_pkg::HEAP_DEPTH);
        flags.cnt_zero         = count_reg == '0;
        flags.cnt_one          = count_reg == CW'(1);
        flags.pos_zero         = pos_reg == '0;
        flags.par_not_heavier  = !par_heavier;
        flags.l_oob            = l_ext >= count_ext;
        flags.second           = second_reg;
        flags.pick_not_lighter = !pick_lighter;
    end

    always_comb
    begin
        unique case (op)
            htme_pkg::OP_RD_PARENT: ram_raddr = parent_idx;
            htme_pkg::OP_POP_TAKE:  ram_raddr = count_m1[IW-1:0];
            htme_pkg::OP_RD_LEFT:   ram_raddr = l_ext[IW-1:0];
            htme_pkg::OP_CAP_LEFT:  ram_raddr = r_ext[IW-1:0];
            default:                ram_raddr = '0;
        endcase
    end

    always_comb
    begin
        ram_waddr = pos_reg;
        unique case (op)
            htme_pkg::OP_PU_MOVE:
            begin
                ram_wen   = par_heavier;
                ram_wdata = ram_rdata;
            end
            htme_pkg::OP_SD_MOVE:
            begin
                ram_wen   = pick_lighter;
                ram_wdata = child_reg;
            end
            htme_pkg::OP_WR_X:
            begin
                ram_wen   = 1'b1;
                ram_wdata = x_reg;
            end
            default:
            begin
                ram_wen   = 1'b0;
                ram_wdata = x_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            next_id_reg <= htme_pkg::FIRST_INTERNAL;
            second_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= emit_op;
            case (op)
                htme_pkg::OP_LEAF_LOAD:  count_reg <= count_reg + CW'(1);
                htme_pkg::OP_POP_TAKE:   count_reg <= count_m1;
                htme_pkg::OP_SET_SECOND: second_reg <= 1'b1;
                htme_pkg::OP_MERGE_PUSH:
                begin
                    count_reg   <= count_reg + CW'(1);
                    next_id_reg <= next_id_reg + DW'(1);
                    second_reg  <= 1'b0;
                end
                htme_pkg::OP_EMIT_ROOT:
                begin
                    count_reg   <= '0;
                    next_id_reg <= htme_pkg::FIRST_INTERNAL;
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (op)
            htme_pkg::OP_LATCH:
            begin
                cmd_reg <= cmd;
                sym_reg <= symbol;
                cnt_reg <= leaf_count;
            end
            htme_pkg::OP_LEAF_LOAD:
            begin
                x_reg   <= '{w: WW'(cnt_reg), id: DW'(sym_reg)};
                pos_reg <= count_reg[IW-1:0];
            end
            htme_pkg::OP_PU_MOVE:
            begin
                if (par_heavier)
                begin
                    pos_reg <= parent_idx;
                end
            end
            htme_pkg::OP_POP_TAKE:
            begin
                if (second_reg)
                begin
                    b_reg <= ram_rdata;
                end
                else
                begin
                    a_reg <= ram_rdata;
                end
            end
            htme_pkg::OP_POP_LAST:
            begin
                x_reg   <= ram_rdata;
                pos_reg <= '0;
            end
            htme_pkg::OP_CAP_LEFT:
            begin
                lw_reg   <= ram_rdata;
                pick_reg <= l_ext[IW-1:0];
            end
            htme_pkg::OP_PICK:
            begin
                // right child only when present and strictly lighter
                if (r_in && (ram_rdata.w < lw_reg.w))
                begin
                    child_reg <= ram_rdata;
                    pick_reg  <= r_ext[IW-1:0];
                end
                else
                begin
                    child_reg <= lw_reg;
                end
            end
            htme_pkg::OP_SD_MOVE:
            begin
                if (pick_lighter)
                begin
                    pos_reg <= pick_reg;
                end
            end
            htme_pkg::OP_MERGE_PUSH:
            begin
                x_reg   <= '{w: sum_sat, id: next_id_reg};
                pos_reg <= count_reg[IW-1:0];
            end
            htme_pkg::OP_EMIT_LEAF:
            begin
                status_reg <= htme_pkg::ST_LEAF;
                left_reg   <= '0;
                right_reg  <= '0;
                node_reg   <= DW'(sym_reg);
                weight_reg <= WW'(cnt_reg);
            end
            htme_pkg::OP_EMIT_ERR:
            begin
                status_reg <= htme_pkg::ST_ERR;
                left_reg   <= '0;
                right_reg  <= '0;
                node_reg   <= '0;
                weight_reg <= '0;
            end
            htme_pkg::OP_EMIT_MERGE:
            begin
                status_reg <= htme_pkg::ST_MERGE;
                // equal weights put the second pop on the left
                if (a_reg.w >= b_reg.w)
                begin
                    left_reg  <= b_reg.id;
                    right_reg <= a_reg.id;
                end
                else
                begin
                    left_reg  <= a_reg.id;
                    right_reg <= b_reg.id;
                end
                node_reg   <= x_reg.id;
                weight_reg <= x_reg.w;
            end
            htme_pkg::OP_EMIT_ROOT:
            begin
                status_reg <= htme_pkg::ST_ROOT;
                left_reg   <= '0;
                right_reg  <= '0;
                node_reg   <= ram_rdata.id;
                weight_reg <= ram_rdata.w;
            end
            default: ;
        endcase
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign left_node  = left_reg;
    assign right_node = right_reg;
    assign new_node   = node_reg;
    assign weight     = weight_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(htme_pkg::HEAP_DEPTH))
        else $error("heap count above depth");

    a_root_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (op == htme_pkg::OP_EMIT_ROOT) |=>
            (count_reg == '0) && (next_id_reg == htme_pkg::FIRST_INTERNAL))
        else $error("root did not clear the heap");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (op == htme_pkg::OP_POP_TAKE) |-> (count_reg != '0))
        else $error("pop from empty heap");

endmodule

`default_nettype wire

// ===== rtl/huffman_tree_merge_engine.sv =====
// channel   signals                                   handshake
// command   cmd, symbol, leaf_count                   start high while busy low
// result    status, left_node, right_node, new_node,  done high for one cycle
//           weight
//
// one command runs at a time; busy is high from the accept edge, the result beat follows
// in the first cycle with busy low again. a leaf push sifts its entry up the heap; a
// merge pops two entries, sifting the heap down after each pop, then pushes their sum
// and sifts it up. all heap steps share the heap ram read port and its registered read.
// reset clears heap count and node ids, not the heap ram.
// results cannot be stalled: each beat is taken in the cycle done is high.
`default_nettype none

module huffman_tree_merge_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          cmd,
    input  wire logic [htme_pkg::SYM_W-1:0]    symbol,
    input  wire logic [htme_pkg::CNT_IN_W-1:0] leaf_count,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [htme_pkg::ID_W-1:0]          left_node,
    output logic [htme_pkg::ID_W-1:0]          right_node,
    output logic [htme_pkg::ID_W-1:0]          new_node,
    output logic [htme_pkg::WGT_W-1:0]         weight
);

    logic [htme_pkg::UPC_W-1:0] upc_reg;
    logic [htme_pkg::UPC_W-1:0] upc_next;
    htme_pkg::ctrl_t            ctrl;
    htme_pkg::flags_t           flags;
    logic                       take_jump;

    logic                       ram_wen;
    logic [htme_pkg::IDX_W-1:0] ram_waddr;
    htme_pkg::entry_t           ram_wdata;
    logic [htme_pkg::IDX_W-1:0] ram_raddr;
    htme_pkg::entry_t           ram_rdata;

    htme_ucode_rom u_rom (
        .upc  (upc_reg),
        .ctrl (ctrl)
    );

    htme_heap_ram u_ram (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    htme_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (ctrl.op),
        .cmd        (cmd),
        .symbol     (symbol),
        .leaf_count (leaf_count),
        .ram_wen    (ram_wen),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .flags      (flags),
        .done       (done),
        .status     (status),
        .left_node  (left_node),
        .right_node (right_node),
        .new_node   (new_node),
        .weight     (weight)
    );

    always_comb
    begin
        unique case (ctrl.cond)
            htme_pkg::C_ALWAYS:           take_jump = 1'b1;
            htme_pkg::C_NSTART:           take_jump = !start;
            htme_pkg::C_IS_MERGE:         take_jump = flags.is_merge;
            htme_pkg::C_FULL:             take_jump = flags.full;
            htme_pkg::C_CNT_ZERO:         take_jump = flags.cnt_zero;
            htme_pkg::C_CNT_ONE:          take_jump = flags.cnt_one;
            htme_pkg::C_POS_ZERO:         take_jump = flags.pos_zero;
            htme_pkg::C_PAR_NOT_HEAVIER:  take_jump = flags.par_not_heavier;
            htme_pkg::C_L_OOB:            take_jump = flags.l_oob;
            htme_pkg::C_SECOND:           take_jump = flags.second;
            htme_pkg::C_PICK_NOT_LIGHTER: take_jump = flags.pick_not_lighter;
            default:                      take_jump = 1'b0;
        endcase
    end

    assign upc_next = take_jump ? ctrl.target : upc_reg + htme_pkg::UPC_W'(1);
    assign busy     = upc_reg != htme_pkg::S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= htme_pkg::S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start the program");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result beat outside the end of a command");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result beats for one command");

endmodule

`default_nettype wire

// ===== test/huffman_tree_merge_engine_tb.sv =====
// self-checking testbench for the huffman tree merge engine: directed and random command beats
// against an in-bench min-heap predictor; depends on rtl/htme_pkg.sv and the engine top level
`default_nettype none

module huffman_tree_merge_engine_tb;

    localparam int TOTAL_CMDS    = 1050;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 200;

    typedef struct {
        logic                          op;
        logic [htme_pkg::SYM_W-1:0]    sym;
        logic [htme_pkg::CNT_IN_W-1:0] count;
    } tree_cmd_t;

    typedef struct {
        logic [1:0]                 status;
        logic [htme_pkg::ID_W-1:0]  lnode;
        logic [htme_pkg::ID_W-1:0]  rnode;
        logic [htme_pkg::ID_W-1:0]  node;
        logic [htme_pkg::WGT_W-1:0] wgt;
    } tree_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          cmd = 1'b0;
    logic [htme_pkg::SYM_W-1:0]    symbol = '0;
    logic [htme_pkg::CNT_IN_W-1:0] leaf_count = '0;
    logic                          busy;
    logic                          done;
    logic [1:0]                    status;
    logic [htme_pkg::ID_W-1:0]     left_node;
    logic [htme_pkg::ID_W-1:0]     right_node;
    logic [htme_pkg::ID_W-1:0]     new_node;
    logic [htme_pkg::WGT_W-1:0]    weight;

    tree_cmd_t    cmd_backlog[$];
    tree_result_t results_due[$];
    tree_cmd_t    cmd_on_bus;

    int mismatch_count = 0;
    int result_index = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;

    // predictor heap
    logic [htme_pkg::WGT_W-1:0] heap_w  [htme_pkg::HEAP_DEPTH];
    logic [htme_pkg::ID_W-1:0]  heap_id [htme_pkg::HEAP_DEPTH];
    int unsigned                heap_size = 0;
    logic [htme_pkg::ID_W-1:0]  next_node_id = htme_pkg::FIRST_INTERNAL;

    huffman_tree_merge_engine uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .symbol     (symbol),
        .leaf_count (leaf_count),
        .done       (done),
        .status     (status),
        .left_node  (left_node),
        .right_node (right_node),
        .new_node   (new_node),
        .weight     (weight)
    );

    always #2 clk = ~clk;

    task automatic heap_swap(int unsigned a, int unsigned b);
        logic [htme_pkg::WGT_W-1:0] tw;
        logic [htme_pkg::ID_W-1:0]  ti;
        tw = heap_w[a];
        ti = heap_id[a];
        heap_w[a] = heap_w[b];
        heap_id[a] = heap_id[b];
        heap_w[b] = tw;
        heap_id[b] = ti;
    endtask

    task automatic heap_push(logic [htme_pkg::WGT_W-1:0] w, logic [htme_pkg::ID_W-1:0] id);
        int unsigned pos;
        int unsigned up;
        pos = heap_size;
        heap_w[pos] = w;
        heap_id[pos] = id;
        heap_size = pos + 1;
        while (pos > 0)
        begin
            up = (pos - 1) / 2;
            if (heap_w[up] > heap_w[pos])
            begin
                heap_swap(up, pos);
                pos = up;
            end
            else
                break;
        end
    endtask

    task automatic heap_pop(output logic [htme_pkg::WGT_W-1:0] w,
                            output logic [htme_pkg::ID_W-1:0] id);
        int unsigned pos;
        int unsigned l;
        int unsigned pick;
        w = heap_w[0];
        id = heap_id[0];
        heap_size = heap_size - 1;
        if (heap_size > 0)
        begin
            heap_w[0] = heap_w[heap_size];
            heap_id[0] = heap_id[heap_size];
            pos = 0;
            // smaller child wins, left on ties; a lone left child is still compared
            while (1)
            begin
                l = pos * 2 + 1;
                if (l >= heap_size)
                    break;
                pick = l;
                if (l + 1 < heap_size && heap_w[l + 1] < heap_w[l])
                    pick = l + 1;
                if (heap_w[pick] < heap_w[pos])
                begin
                    heap_swap(pick, pos);
                    pos = pick;
                end
                else
                    break;
            end
        end
    endtask

    task automatic predict_tree_step(tree_cmd_t c);
        tree_result_t               r;
        logic [htme_pkg::WGT_W-1:0] wa;
        logic [htme_pkg::WGT_W-1:0] wb;
        logic [htme_pkg::ID_W-1:0]  ia;
        logic [htme_pkg::ID_W-1:0]  ib;
        logic [htme_pkg::WGT_W:0]   sum;
        r.status = htme_pkg::ST_ERR;
        r.lnode = '0;
        r.rnode = '0;
        r.node = '0;
        r.wgt = '0;
        if (c.op == htme_pkg::CMD_LEAF)
        begin
            if (heap_size < htme_pkg::HEAP_DEPTH)
            begin
                heap_push({8'd0, c.count}, {1'b0, c.sym});
                r.status = htme_pkg::ST_LEAF;
                r.node = {1'b0, c.sym};
                r.wgt = {8'd0, c.count};
            end
        end
        else if (heap_size == 1)
        begin
            r.status = htme_pkg::ST_ROOT;
            r.node = heap_id[0];
            r.wgt = heap_w[0];
            heap_size = 0;
            next_node_id = htme_pkg::FIRST_INTERNAL;
        end
        else if (heap_size >= 2)
        begin
            heap_pop(wa, ia);
            heap_pop(wb, ib);
            // equal weights put the second entry popped on the left
            if (wa >= wb)
            begin
                r.lnode = ib;
                r.rnode = ia;
            end
            else
            begin
                r.lnode = ia;
                r.rnode = ib;
            end
            sum = {1'b0, wa} + {1'b0, wb};
            r.wgt = sum[htme_pkg::WGT_W] ? '1 : sum[htme_pkg::WGT_W-1:0];
            r.node = next_node_id;
            heap_push(r.wgt, next_node_id);
            next_node_id = next_node_id + 1'b1;
            r.status = htme_pkg::ST_MERGE;
        end
        results_due.push_back(r);
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch on result beat %0d at %0t: %s", result_index, $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [htme_pkg::WGT_W-1:0] got,
                               logic [htme_pkg::WGT_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    function automatic logic [htme_pkg::SYM_W-1:0] rand_sym();
        return htme_pkg::SYM_W'($urandom_range(0, 255));
    endfunction

    function automatic void add_leaf(logic [htme_pkg::SYM_W-1:0] s,
                                     logic [htme_pkg::CNT_IN_W-1:0] c);
        tree_cmd_t t;
        t.op = htme_pkg::CMD_LEAF;
        t.sym = s;
        t.count = c;
        cmd_backlog.push_back(t);
    endfunction

    // symbol and count are don't-care on a merge, so they carry noise
    function automatic void add_merge();
        tree_cmd_t t;
        t.op = htme_pkg::CMD_MERGE;
        t.sym = rand_sym();
        t.count = $urandom();
        cmd_backlog.push_back(t);
    endfunction

    function automatic logic [htme_pkg::CNT_IN_W-1:0] rand_count(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 7);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return ($urandom_range(0, 4) == 0) ? 32'd0 : (32'd1 << $urandom_range(0, 31));
        endcase
    endfunction

    // command driver: bursts of beats separated by idle gaps counted while the engine is free
    always @(posedge clk)
    begin
        logic take;
        logic next_start;
        take = start && !busy;
        next_start = start;
        if (rst_n)
        begin
            if (take)
                predict_tree_step(cmd_on_bus);
            if (!start || take)
            begin
                next_start = 1'b0;
                if (gap_left > 0)
                begin
                    if (!busy)
                        gap_left--;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    cmd <= cmd_on_bus.op;
                    symbol <= cmd_on_bus.sym;
                    leaf_count <= cmd_on_bus.count;
                    next_start = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
                start <= next_start;
            end
        end
    end

    // result monitor: every done beat is taken, the receiver has no way to stall
    always @(posedge clk)
    begin
        tree_result_t want;
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = results_due.pop_front();
                check_field("status", htme_pkg::WGT_W'(status),
                            htme_pkg::WGT_W'(want.status));
                check_field("left_node", htme_pkg::WGT_W'(left_node),
                            htme_pkg::WGT_W'(want.lnode));
                check_field("right_node", htme_pkg::WGT_W'(right_node),
                            htme_pkg::WGT_W'(want.rnode));
                check_field("new_node", htme_pkg::WGT_W'(new_node),
                            htme_pkg::WGT_W'(want.node));
                check_field("weight", weight, want.wgt);
            end
            result_index++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("stalled for %0d cycles with %0d commands and %0d results pending",
                         idle_cycles, cmd_backlog.size(), results_due.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int mode;
        int live;

        // empty heap, single leaf root, zero counts
        add_merge();
        add_leaf(8'd0, 32'd0);
        add_merge();
        add_merge();
        // max symbol and count, equal weights
        add_leaf(8'd255, 32'hFFFF_FFFF);
        add_leaf(8'd170, 32'hFFFF_FFFF);
        add_merge();
        add_merge();
        // small tree with distinct weights and a zero tie
        add_leaf(8'd85, 32'd5);
        add_leaf(8'd3, 32'd2);
        add_leaf(8'd7, 32'd9);
        add_leaf(8'd1, 32'd0);
        add_leaf(8'd128, 32'd0);
        add_merge();
        add_merge();
        add_merge();
        add_merge();
        add_merge();
        add_merge();

        // fill the heap, overflow it, drain it deep; then wrap node ids and saturate the weight
        repeat (htme_pkg::HEAP_DEPTH) add_leaf(rand_sym(), rand_count(2));
        add_leaf(rand_sym(), $urandom());
        repeat (htme_pkg::HEAP_DEPTH - 1) add_merge();
        repeat (6)
        begin
            add_leaf(rand_sym(), 32'hFFFF_FFFF);
            add_merge();
        end
        add_merge();
        add_merge();

        // random trees, mostly well formed, with stray leaves and extra merges mixed in
        while (cmd_backlog.size() < TOTAL_CMDS)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 12);
            mode = $urandom_range(0, 3);
            repeat (n) add_leaf(rand_sym(), rand_count(mode));
            live = n;
            while (live > 0)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    add_leaf(rand_sym(), $urandom());
                    live++;
                end
                add_merge();
                live--;
            end
            if ($urandom_range(0, 3) == 0)
                add_merge();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (cmd_backlog.size() > 0 || start || results_due.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
